/* src/binned_legendre_moment_accumulator_unit_macros.svh */
// ============================================================================
// Binned Legendre moment accumulator - assertion macros
// Shared concurrent assertion forms for the port checker
// ============================================================================
`ifndef BINNED_LEGENDRE_MOMENT_ACCUMULATOR_UNIT_MACROS_SVH
`define BINNED_LEGENDRE_MOMENT_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BLMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BLMA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/blma_pkg.sv */
// ============================================================================
// Binned Legendre moment accumulator - package
// Widths, opcodes, register indexes and reset values shared by the block
// ============================================================================
package blma_pkg;

    // default sizing
    localparam int NUM_BINS_DEF  = 64;
    localparam int SUM_WIDTH_DEF = 40;
    localparam int NUM_MOMENTS   = 6;

    // item fields
    localparam int OPCODE_W = 2;
    localparam int MASS_W   = 16;
    localparam int COS_W    = 16;
    localparam int SEL_W    = 6;

    typedef logic [OPCODE_W-1:0] opcode_t;

    localparam opcode_t OP_ACCUM = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CENTER_W    = 16;
    localparam int SPACING_W   = 12;
    localparam int WINDOW_W    = 12;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_FIRST_CENTER = 2'd0;
    localparam cfg_index_t REG_BIN_SPACING  = 2'd1;
    localparam cfg_index_t REG_HALF_WINDOW  = 2'd2;

    localparam logic [CENTER_W-1:0]  FIRST_CENTER_RST = 16'd14550;
    localparam logic [SPACING_W-1:0] BIN_SPACING_RST  = 12'd100;
    localparam logic [WINDOW_W-1:0]  HALF_WINDOW_RST  = 12'd50;

    // fixed point: x and its powers in Q1.15 with one spare bit for +1.0
    localparam int FRAC_W = 15;
    localparam int X_W    = 17;
    localparam int P_W    = 20;
    localparam int POLY_W = 26;
    localparam int ONE_Q  = 32768;

endpackage

/* src/binned_legendre_moment_accumulator_unit.sv */
// ============================================================================
// Binned Legendre moment accumulator
// Sums Legendre moments P0..P5 of x = -cos(theta) into windowed mass bins
// ============================================================================
// Usage
//   Input channel (in_valid/in_ready) takes one item: opcode, event_mass,
//   cos_theta and bin_select. Accumulate adds P0..P5 to every bin whose
//   centre lies strictly within half_window of the mass; read returns the six
//   sums of bin_select on the output channel (out_valid/out_ready); clear
//   zeroes all sums. Opcode 3 is dropped.
//   Config channel (cfg_valid/cfg_ready) is always ready and writes
//   first_center, bin_spacing or half_window; write only while idle.
//   Sequence: one shared 17x17 multiplier forms x^2..x^5 in turn, then the
//   polynomials are registered, then the scan visits one bin a cycle while
//   bins do not match and pauses on a bin that matches, as each of its six
//   sums is read then written through the single memory port. A read item
//   reads its six sums through the same port. Clear and opcode 3 leave the
//   block idle.
//   A read result waits in the output register while the receiver stalls;
//   accumulate and clear items still run, a further read waits for the slot.
//   Reset clears the per-bin valid flags, so every sum reads as zero; no
//   clearing pass is needed.
// ============================================================================
module binned_legendre_moment_accumulator_unit
    import blma_pkg::*;
#(
    parameter int NUM_BINS  = NUM_BINS_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [OPCODE_W-1:0]         opcode,
    input  logic [MASS_W-1:0]           event_mass,
    input  logic signed [COS_W-1:0]     cos_theta,
    input  logic [SEL_W-1:0]            bin_select,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SUM_WIDTH-1:0] sum_p0,
    output logic signed [SUM_WIDTH-1:0] sum_p1,
    output logic signed [SUM_WIDTH-1:0] sum_p2,
    output logic signed [SUM_WIDTH-1:0] sum_p3,
    output logic signed [SUM_WIDTH-1:0] sum_p4,
    output logic signed [SUM_WIDTH-1:0] sum_p5,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int DEPTH     = NUM_BINS * NUM_MOMENTS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CTR_W     = 17 + BIN_W;
    localparam int DIFF_W    = CTR_W + 1;
    localparam int SEL_EXT_W = 9;
    localparam int J_W       = 3;

    localparam logic [J_W-1:0]   J_LAST   = J_W'(NUM_MOMENTS - 1);
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(NUM_MOMENTS);
    localparam logic [1:0]       MUL_LAST = 2'd3;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_POLY = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [NUM_BINS-1:0] valid_reg, valid_next;

    logic [CENTER_W-1:0]  first_center_reg;
    logic [SPACING_W-1:0] bin_spacing_reg;
    logic [WINDOW_W-1:0]  half_window_reg;

    // datapath registers
    logic                     rd_op_reg;
    logic                     rd_ok_reg;
    logic [MASS_W-1:0]        mass_reg;
    logic signed [X_W-1:0]    x_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic [1:0]               mstep_reg;
    logic signed [P_W-1:0]    p_reg [NUM_MOMENTS];
    logic [CTR_W-1:0]         center_reg;
    logic [BIN_W-1:0]         bin_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic [J_W-1:0]           j_reg;
    logic signed [SUM_WIDTH-1:0] out_sum_reg [NUM_MOMENTS];

    // sum memory
    logic [SUM_WIDTH-1:0] sum_mem [DEPTH];
    logic [SUM_WIDTH-1:0] rdata_reg;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 mem_we;
    logic [SUM_WIDTH-1:0] mem_wdata;

    logic                  in_fire;
    logic [SEL_EXT_W-1:0]  sel_ext;
    logic [BIN_W-1:0]      sel_bin;
    logic [ADDR_W-1:0]     sel_base;
    logic signed [X_W-1:0] cos_ext;
    logic signed [X_W-1:0] mul_a;
    logic signed [2*X_W-1:0] prod;
    logic signed [X_W-1:0] pw;
    logic signed [POLY_W-1:0] e1, e2, e3, e4, e5;
    logic signed [POLY_W-1:0] t2, t3, t4, t5;
    logic [DIFF_W-1:0]     diff, abs_diff;
    logic                  match;
    logic                  last_bin;
    logic                  row_done;
    logic                  adv_bin;
    logic signed [SUM_WIDTH-1:0] acc_in;
    logic signed [SUM_WIDTH:0]   acc_sum;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    assign sum_p0 = out_sum_reg[0];
    assign sum_p1 = out_sum_reg[1];
    assign sum_p2 = out_sum_reg[2];
    assign sum_p3 = out_sum_reg[3];
    assign sum_p4 = out_sum_reg[4];
    assign sum_p5 = out_sum_reg[5];

    // read-bin decode: range check and row base of six entries
    assign sel_ext  = SEL_EXT_W'(bin_select);
    assign sel_bin  = sel_ext[BIN_W-1:0];
    assign sel_base = ADDR_W'({sel_bin, 2'b00}) + ADDR_W'({sel_bin, 1'b0});
    assign cos_ext  = X_W'(cos_theta);

    // shared multiplier: next power of x, floor shift by the fraction width
    always_comb
    begin
        unique case (mstep_reg)
            2'd0:    mul_a = x_reg;
            2'd1:    mul_a = x2_reg;
            2'd2:    mul_a = x3_reg;
            default: mul_a = x4_reg;
        endcase
    end

    assign prod = mul_a * x_reg;
    assign pw   = prod[X_W+FRAC_W-1:FRAC_W];

    // polynomial terms from the stored powers
    always_comb
    begin
        e1 = POLY_W'(x_reg);
        e2 = POLY_W'(x2_reg);
        e3 = POLY_W'(x3_reg);
        e4 = POLY_W'(x4_reg);
        e5 = POLY_W'(x5_reg);
        t2 = POLY_W'(3 * e2 - ONE_Q);
        t3 = POLY_W'(5 * e3 - 3 * e1);
        t4 = POLY_W'(35 * e4 - 30 * e2 + 3 * ONE_Q);
        t5 = POLY_W'(63 * e5 - 70 * e3 + 15 * e1);
    end

    // window compare for the current bin centre
    assign diff     = DIFF_W'(mass_reg) - DIFF_W'(center_reg);
    assign abs_diff = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    assign match    = (abs_diff < DIFF_W'(half_window_reg));
    assign last_bin = (bin_reg == BIN_LAST);
    assign row_done = (j_reg == J_LAST);

    // memory port: one address for the read and the write-back
    assign mem_addr = base_reg + ADDR_W'(j_reg);
    assign mem_we   = (state_reg == S_WR) && !rd_op_reg;

    // saturating add of the selected moment; a never-written row reads zero
    assign acc_in  = valid_reg[bin_reg] ? $signed(rdata_reg) : '0;
    assign acc_sum = {acc_in[SUM_WIDTH-1], acc_in} + (SUM_WIDTH+1)'(p_reg[j_reg]);

    always_comb
    begin
        if (acc_sum[SUM_WIDTH] != acc_sum[SUM_WIDTH-1])
        begin
            mem_wdata = acc_sum[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            mem_wdata = acc_sum[SUM_WIDTH-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        valid_next     = valid_reg;
        adv_bin        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_ACCUM: state_next = S_MUL;
                        OP_READ:  state_next = S_RD;
                        OP_CLEAR: valid_next = '0;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:
            begin
                if (mstep_reg == MUL_LAST)
                begin
                    state_next = S_POLY;
                end
            end
            S_POLY:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (match)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    adv_bin = 1'b1;
                    if (last_bin)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD:
            begin
                // a read waits until the output slot is free
                if (!(rd_op_reg && out_valid_reg))
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                if (!row_done)
                begin
                    state_next = S_RD;
                end
                else if (rd_op_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    valid_next[bin_reg] = 1'b1;
                    adv_bin             = 1'b1;
                    state_next          = last_bin ? S_IDLE : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            valid_reg        <= '0;
            first_center_reg <= FIRST_CENTER_RST;
            bin_spacing_reg  <= BIN_SPACING_RST;
            half_window_reg  <= HALF_WINDOW_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FIRST_CENTER: first_center_reg <= cfg_data[CENTER_W-1:0];
                    REG_BIN_SPACING:  bin_spacing_reg  <= cfg_data[SPACING_W-1:0];
                    REG_HALF_WINDOW:  half_window_reg  <= cfg_data[WINDOW_W-1:0];
                    default:          first_center_reg <= first_center_reg;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_op_reg  <= (opcode == OP_READ);
            rd_ok_reg  <= (sel_ext < SEL_EXT_W'(NUM_BINS));
            mass_reg   <= event_mass;
            x_reg      <= -cos_ext;
            mstep_reg  <= 2'd0;
            j_reg      <= '0;
            center_reg <= CTR_W'(first_center_reg);
            bin_reg    <= (opcode == OP_READ) ? sel_bin : '0;
            base_reg   <= (opcode == OP_READ) ? sel_base : '0;
        end

        // powers x^2..x^5, one per cycle
        if (state_reg == S_MUL)
        begin
            mstep_reg <= mstep_reg + 2'd1;
            unique case (mstep_reg)
                2'd0:    x2_reg <= pw;
                2'd1:    x3_reg <= pw;
                2'd2:    x4_reg <= pw;
                default: x5_reg <= pw;
            endcase
        end

        if (state_reg == S_POLY)
        begin
            p_reg[0] <= P_W'(ONE_Q);
            p_reg[1] <= P_W'(x_reg);
            p_reg[2] <= P_W'(t2 >>> 1);
            p_reg[3] <= P_W'(t3 >>> 1);
            p_reg[4] <= P_W'(t4 >>> 3);
            p_reg[5] <= P_W'(t5 >>> 3);
        end

        // step through the six moments of a row
        if (state_reg == S_WR)
        begin
            j_reg <= row_done ? '0 : j_reg + 1'b1;
            if (rd_op_reg)
            begin
                out_sum_reg[j_reg] <= (rd_ok_reg && valid_reg[bin_reg])
                                      ? $signed(rdata_reg) : '0;
            end
        end

        // next bin centre and row
        if (adv_bin)
        begin
            bin_reg    <= bin_reg + 1'b1;
            center_reg <= center_reg + CTR_W'(bin_spacing_reg);
            base_reg   <= base_reg + ROW_STEP;
        end
    end

    // sum memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= sum_mem[mem_addr];
    end

endmodule

/* src/blma_checker.sv */
// ============================================================================
// Binned Legendre moment accumulator - port checker
// Watches the top-level ports over time and reports handshake and item slips
// ============================================================================
`include "binned_legendre_moment_accumulator_unit_macros.svh"

module blma_checker
    import blma_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [OPCODE_W-1:0]         opcode,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [SUM_WIDTH-1:0] sum_p0,
    input logic signed [SUM_WIDTH-1:0] sum_p5
);

    // a stalled result stays offered
    `BLMA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // a stalled result keeps its payload (sum_p0 and sum_p5 are checked)
    `BLMA_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(sum_p0) && $stable(sum_p5), "result payload changed while stalled")

    // accumulate and read items keep the block busy for the next cycle
    `BLMA_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready && (opcode == OP_ACCUM || opcode == OP_READ), !in_ready, "ready after a multi-cycle item")

    // a clear item never produces a result
    `BLMA_ASSERT_NXT(a_clear_silent, clk, rst_n, in_valid && in_ready && opcode == OP_CLEAR && !out_valid, !out_valid, "result after a clear item")

endmodule

bind binned_legendre_moment_accumulator_unit blma_checker #(
    .SUM_WIDTH (SUM_WIDTH)
) u_blma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sum_p0    (sum_p0),
    .sum_p5    (sum_p5)
);
